// File: hdl/ahc_pkg.sv
// ----------------------------------------------------------------------------
// ahc_pkg
// Types, marker texts and helper functions for the armor header classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ahc_pkg;

   localparam int unsigned MARK_BYTES = 34;

   localparam int unsigned BEGIN_LEN = 15;
   localparam int unsigned END_LEN   = 13;
   localparam int unsigned MSG_LEN   = 27;
   localparam int unsigned SMSG_LEN  = 34;
   localparam int unsigned SIG_LEN   = 29;

   typedef logic [8*MARK_BYTES-1:0] mark_text_type;

   // marker texts, left aligned and NUL padded
   localparam mark_text_type BEGIN_TEXT =
      {"-----BEGIN PGP ", {(MARK_BYTES-BEGIN_LEN){8'h00}}};
   localparam mark_text_type END_TEXT =
      {"-----END PGP ", {(MARK_BYTES-END_LEN){8'h00}}};
   localparam mark_text_type MSG_TEXT =
      {"-----BEGIN PGP MESSAGE-----", {(MARK_BYTES-MSG_LEN){8'h00}}};
   localparam mark_text_type SMSG_TEXT = "-----BEGIN PGP SIGNED MESSAGE-----";
   localparam mark_text_type SIG_TEXT =
      {"-----BEGIN PGP SIGNATURE-----", {(MARK_BYTES-SIG_LEN){8'h00}}};

   // candidate flag positions
   localparam int unsigned F_BEGIN = 0;
   localparam int unsigned F_END   = 1;
   localparam int unsigned F_MSG   = 2;
   localparam int unsigned F_SMSG  = 3;
   localparam int unsigned F_SIG   = 4;

   typedef logic [4:0] alive_type;
   typedef logic [2:0] kind_type;

   localparam kind_type KIND_MSG     = 3'd0;
   localparam kind_type KIND_SMSG    = 3'd1;
   localparam kind_type KIND_SIG     = 3'd2;
   localparam kind_type KIND_UNKNOWN = 3'd3;
   localparam kind_type KIND_ERROR   = 3'd4;

   localparam logic [7:0] CHAR_LF = 8'h0A;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } req_item_type;

   typedef struct packed {
      logic     valid;
      kind_type armor_kind;
   } scan_result_type;

   function automatic logic [7:0] mark_char(mark_text_type text, logic [5:0] idx);
      logic [7:0] ch;
      ch = 8'h00;
      if (int'(idx) < MARK_BYTES) begin
         ch = text[8*(MARK_BYTES-1-int'(idx)) +: 8];
      end
      return ch;
   endfunction

   function automatic logic is_blank(logic [7:0] b);
      return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
   endfunction

   function automatic kind_type classify(alive_type alive, logic ge_msg,
                                         logic ge_smsg, logic ge_sig);
      kind_type kind;
      priority if (alive[F_MSG] && ge_msg) begin
         kind = KIND_MSG;
      end else if (alive[F_SMSG] && ge_smsg) begin
         kind = KIND_SMSG;
      end else if (alive[F_SIG] && ge_sig) begin
         kind = KIND_SIG;
      end else begin
         kind = KIND_UNKNOWN;
      end
      return kind;
   endfunction

endpackage

`default_nettype wire

// File: hdl/ahc_if.sv
// ----------------------------------------------------------------------------
// ahc_req_if / ahc_rsp_if
// Valid/ready channels for the byte stream and the classification result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ahc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_input;

   modport source (output valid, output data_byte, output end_of_input, input ready);
   modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface ahc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] armor_kind;

   modport source (output valid, output armor_kind, input ready);
   modport sink   (input valid, input armor_kind, output ready);
endinterface

`default_nettype wire

// File: hdl/armor_header_classifier_top.sv
// ----------------------------------------------------------------------------
// armor_header_classifier_top
// Classifies the armor header line at the start of a text stream.
//
// req_if carries one byte per transaction, or an end_of_input marker that
// closes the stream and re-arms the block. rsp_if carries at most one
// armor_kind per stream: message, signed message, signature, unknown header
// or error. Only the first chunk (up to LINE_CHARS bytes) of each line is
// examined.
// A result passes through the input register and then the result register
// once the transaction that causes it is accepted.
// Throughput: one transaction per cycle while rsp_if is not stalled, set by
// the single scan stage between the input register and the result register.
// When rsp_if is stalled, the result register holds and the input register
// takes one more transaction before req_if.ready drops.
// Synchronous reset empties both registers and returns the scanner to line
// start, first chunk, no header seen.
// ----------------------------------------------------------------------------
`default_nettype none

module armor_header_classifier_top #(
   parameter int unsigned LINE_CHARS = 511
) (
   input  logic        clock,
   input  logic        reset,
   ahc_req_if.sink     req_if,
   ahc_rsp_if.source   rsp_if
);
   import ahc_pkg::*;

   logic            in_vld_ff, in_vld_in;
   req_item_type    in_item_ff;
   logic            rsp_vld_ff, rsp_vld_in;
   kind_type        rsp_kind_ff, rsp_kind_in;
   logic            advance;
   scan_result_type scan_res;

   assign advance      = in_vld_ff && (!rsp_vld_ff || rsp_if.ready);
   assign req_if.ready = !in_vld_ff || advance;

   ahc_scan #(
      .LINE_CHARS (LINE_CHARS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .item_fire (advance),
      .item      (in_item_ff),
      .result    (scan_res)
   );

   always_comb begin
      in_vld_in   = req_if.ready ? req_if.valid : in_vld_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_kind_in = rsp_kind_ff;
      priority if (advance) begin
         rsp_vld_in  = scan_res.valid;
         rsp_kind_in = scan_res.armor_kind;
      end else if (rsp_if.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready) begin
         in_item_ff.data_byte    <= req_if.data_byte;
         in_item_ff.end_of_input <= req_if.end_of_input;
      end
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_if.valid      = rsp_vld_ff;
   assign rsp_if.armor_kind = rsp_kind_ff;

endmodule

`default_nettype wire

// File: hdl/ahc_scan.sv
// ----------------------------------------------------------------------------
// ahc_scan
// Line-start scanner: column, match flags and phase, updated once per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ahc_scan #(
   parameter int unsigned LINE_CHARS = 511
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_fire,
   input  ahc_pkg::req_item_type   item,
   output ahc_pkg::scan_result_type result
);
   import ahc_pkg::*;

   localparam int unsigned ColW = $clog2(LINE_CHARS + 1);

   localparam logic PHASE_SCAN = 1'b0;
   localparam logic PHASE_DONE = 1'b1;

   logic            phase_ff, phase_in;
   logic [ColW-1:0] col_ff, col_in;
   logic            chk_ff, chk_in;
   alive_type       alive_ff, alive_in;
   logic            hdr_ff, hdr_in;

   logic [7:0]      b;
   logic [5:0]      idx;
   logic [ColW-1:0] col_inc;
   alive_type       alive_n;
   logic            hdr_n;
   logic            close;
   kind_type        eoi_kind;
   kind_type        line_kind;

   assign b       = item.data_byte;
   assign idx     = col_ff[5:0];
   assign col_inc = col_ff + ColW'(1);

   always_comb begin
      alive_n = alive_ff;
      if (chk_ff) begin
         if (col_ff < ColW'(BEGIN_LEN) && b != mark_char(BEGIN_TEXT, idx)) begin
            alive_n[F_BEGIN] = 1'b0;
         end
         if (col_ff < ColW'(END_LEN) && b != mark_char(END_TEXT, idx)) begin
            alive_n[F_END] = 1'b0;
         end
         if (col_ff < ColW'(MSG_LEN) ? b != mark_char(MSG_TEXT, idx) : !is_blank(b)) begin
            alive_n[F_MSG] = 1'b0;
         end
         if (col_ff < ColW'(SMSG_LEN) ? b != mark_char(SMSG_TEXT, idx) : !is_blank(b)) begin
            alive_n[F_SMSG] = 1'b0;
         end
         if (col_ff < ColW'(SIG_LEN) ? b != mark_char(SIG_TEXT, idx) : !is_blank(b)) begin
            alive_n[F_SIG] = 1'b0;
         end
      end
   end

   assign hdr_n = hdr_ff || (chk_ff && col_ff == ColW'(BEGIN_LEN - 1) && alive_n[F_BEGIN]);
   assign close = (b == CHAR_LF) || (col_inc == ColW'(LINE_CHARS));

   assign eoi_kind  = hdr_ff ? classify(alive_ff, col_ff >= ColW'(MSG_LEN),
                                        col_ff >= ColW'(SMSG_LEN),
                                        col_ff >= ColW'(SIG_LEN))
                             : KIND_ERROR;
   assign line_kind = classify(alive_n, col_inc >= ColW'(MSG_LEN),
                               col_inc >= ColW'(SMSG_LEN), col_inc >= ColW'(SIG_LEN));

   always_comb begin
      result   = '0;
      phase_in = phase_ff;
      col_in   = col_ff;
      chk_in   = chk_ff;
      alive_in = alive_ff;
      hdr_in   = hdr_ff;
      priority if (item.end_of_input) begin
         result.valid      = (phase_ff == PHASE_SCAN);
         result.armor_kind = eoi_kind;
         phase_in = PHASE_SCAN;
         col_in   = '0;
         chk_in   = 1'b1;
         alive_in = '1;
         hdr_in   = 1'b0;
      end else if (phase_ff == PHASE_DONE) begin
         // bytes after a result are dropped
      end else if (chk_ff && col_ff == ColW'(END_LEN - 1) && alive_n[F_END]) begin
         result.valid      = 1'b1;
         result.armor_kind = KIND_ERROR;
         phase_in = PHASE_DONE;
      end else if (close && hdr_n) begin
         result.valid      = 1'b1;
         result.armor_kind = line_kind;
         phase_in = PHASE_DONE;
      end else if (close) begin
         col_in   = '0;
         chk_in   = (b == CHAR_LF);
         alive_in = '1;
         hdr_in   = hdr_n;
      end else begin
         col_in   = col_inc;
         alive_in = alive_n;
         hdr_in   = hdr_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_SCAN;
         col_ff   <= '0;
         chk_ff   <= 1'b1;
         alive_ff <= '1;
         hdr_ff   <= 1'b0;
      end else if (item_fire) begin
         phase_ff <= phase_in;
         col_ff   <= col_in;
         chk_ff   <= chk_in;
         alive_ff <= alive_in;
         hdr_ff   <= hdr_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/ahc_checker.sv
// ----------------------------------------------------------------------------
// ahc_checker
// Port-level checks for the armor header classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ahc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_armor_kind
);
   import ahc_pkg::*;

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_armor_kind))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_armor_kind <= KIND_ERROR)
      else $error("armor_kind out of range");

   // input side never blocks while the result register is empty
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req not ready with empty result register");

   // no result without a transaction in flight
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !(req_valid && req_ready)) ##1 !rsp_valid |=> !rsp_valid)
      else $error("result without a transaction");

endmodule

bind armor_header_classifier_top ahc_checker u_ahc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_armor_kind (rsp_if.armor_kind)
);

`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for armor_header_classifier_top. A table of directed
// streams, then randomly built streams, are sent one byte per transaction
// in bursts with random gaps while the response side stalls on a pattern of
// its own. The scanner model of the header logic, or a fixed table row, gives
// each expected armor_kind; every response transaction is checked in order.
// ----------------------------------------------------------------------------

module tb_top;
   import ahc_pkg::*;

   localparam int LINE_CHARS      = 511;
   localparam int DRAIN_CYCLES    = 20;
   localparam int DRAIN_LIMIT     = 10000;
   localparam int MIN_SCAN_ITEMS  = 1000;

   typedef enum logic [1:0] {LINE_SCAN, RESULT_HELD} scan_phase_type;

   typedef struct {
      string      head;
      int         fill_n;
      logic [7:0] fill_b;
      string      tail;
      bit         fixed;
      kind_type   kind;
   } stream_case_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ahc_req_if req_ch ();
   ahc_rsp_if rsp_ch ();

   armor_header_classifier_top #(
      .LINE_CHARS (LINE_CHARS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   string begin_mark = "-----BEGIN PGP ";
   string end_mark   = "-----END PGP ";
   string msg_line   = "-----BEGIN PGP MESSAGE-----";
   string smsg_line  = "-----BEGIN PGP SIGNED MESSAGE-----";
   string sig_line   = "-----BEGIN PGP SIGNATURE-----";

   // scanner model state
   scan_phase_type scan_phase;
   int             column;
   bit             first_chunk;
   alive_type      alive;
   bit             header_seen;

   kind_type    expected_kinds[$];
   logic [7:0]  stream_bytes[$];
   int          mismatches  = 0;
   int          scan_items  = 0;
   int          burst_left  = 0;
   bit          fixed_row   = 1'b0;
   kind_type    fixed_kind  = KIND_ERROR;

   int          stall_mode = 0;
   int          stall_left = 0;

   stream_case_type directed_cases [17] = '{
      '{"", 0, 8'h00, "", 1'b1, KIND_ERROR},
      '{"-----BEGIN PGP MESSAGE-----\n", 0, 8'h00, "ignored text\n", 1'b1, KIND_MSG},
      '{"-----BEGIN PGP SIGNED MESSAGE-----\015\n", 0, 8'h00, "", 1'b1, KIND_SMSG},
      '{"-----BEGIN PGP SIGNATURE----- \t\015\n", 0, 8'h00, "", 1'b1, KIND_SIG},
      '{"-----BEGIN PGP PUBLIC KEY BLOCK-----\n", 0, 8'h00, "", 1'b1, KIND_UNKNOWN},
      '{"-----END PGP MESSAGE-----\n", 0, 8'h00, "", 1'b1, KIND_ERROR},
      '{"-----END PGP ", 0, 8'h00, "", 1'b1, KIND_ERROR},
      '{"comment line\n-----BEGIN PGP SIGNATURE-----", 0, 8'h00, "", 1'b0, KIND_ERROR},
      '{"-----BEGIN PGP MESSAGE-----X\n", 0, 8'h00, "", 1'b1, KIND_UNKNOWN},
      '{"-----BEGIN PGP ", 0, 8'h00, "", 1'b1, KIND_UNKNOWN},
      '{"", LINE_CHARS, 8'h41, "-----BEGIN PGP MESSAGE-----\n", 1'b0, KIND_ERROR},
      '{"-----BEGIN PGP MESSAGE-----", LINE_CHARS - 27, 8'h20, "xyz", 1'b0, KIND_ERROR},
      '{"", 3, 8'h00, "\n-----BEGIN PGP MESSAGE-----\n", 1'b0, KIND_ERROR},
      '{"", 4, 8'hFF, "\n", 1'b0, KIND_ERROR},
      '{"-----BEGIN PGP SIGNED MESSAGE----", 0, 8'h00, "", 1'b0, KIND_ERROR},
      '{"\n\n-----END PGX", 0, 8'h00, "\n-----BEGIN PGP MESSAGE-----\t\t\n", 1'b0, KIND_ERROR},
      '{"", LINE_CHARS, 8'h42, "\n-----BEGIN PGP SIGNATURE-----\n", 1'b0, KIND_ERROR}
   };

   initial begin : clock_gen
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      #10_000_000;
      $display("armor_header_classifier_top verification failed");
      $finish;
   end

   function automatic void restart_scan();
      scan_phase  = LINE_SCAN;
      column      = 0;
      first_chunk = 1'b1;
      alive       = '1;
      header_seen = 1'b0;
   endfunction

   function automatic bit is_space(logic [7:0] b);
      return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
   endfunction

   function automatic kind_type header_kind();
      if (alive[F_MSG] && column >= msg_line.len()) begin
         return KIND_MSG;
      end
      if (alive[F_SMSG] && column >= smsg_line.len()) begin
         return KIND_SMSG;
      end
      if (alive[F_SIG] && column >= sig_line.len()) begin
         return KIND_SIG;
      end
      return KIND_UNKNOWN;
   endfunction

   function automatic void drop_on_prefix(int flag, string mark, logic [7:0] b);
      if (column < mark.len() && b != 8'(mark[column])) begin
         alive[flag] = 1'b0;
      end
   endfunction

   function automatic void drop_on_line(int flag, string line, logic [7:0] b);
      bit ok;
      if (column < line.len()) begin
         ok = (b == 8'(line[column]));
      end else begin
         ok = is_space(b);
      end
      if (!ok) begin
         alive[flag] = 1'b0;
      end
   endfunction

   // one transaction through the scanner model; returns 1 when a kind is due
   function automatic bit scan_step(logic [7:0] b, logic eoi, output kind_type kind);
      bit produced;
      kind = KIND_ERROR;
      if (eoi) begin
         produced = (scan_phase == LINE_SCAN);
         if (produced && header_seen) begin
            kind = header_kind();
         end
         restart_scan();
         return produced;
      end
      if (scan_phase != LINE_SCAN) begin
         return 1'b0;
      end
      if (first_chunk) begin
         drop_on_prefix(F_BEGIN, begin_mark, b);
         drop_on_prefix(F_END, end_mark, b);
         drop_on_line(F_MSG, msg_line, b);
         drop_on_line(F_SMSG, smsg_line, b);
         drop_on_line(F_SIG, sig_line, b);
         if (column == end_mark.len() - 1 && alive[F_END]) begin
            scan_phase = RESULT_HELD;
            return 1'b1;
         end
         if (column == begin_mark.len() - 1 && alive[F_BEGIN]) begin
            header_seen = 1'b1;
         end
      end
      column++;
      if (b == CHAR_LF || column >= LINE_CHARS) begin
         if (header_seen) begin
            kind       = header_kind();
            scan_phase = RESULT_HELD;
            return 1'b1;
         end
         first_chunk = (b == CHAR_LF);
         column      = 0;
         alive       = '1;
      end
      return 1'b0;
   endfunction

   function automatic string marker_text(int idx);
      case (idx)
         0:       return msg_line;
         1:       return smsg_line;
         2:       return sig_line;
         3:       return begin_mark;
         default: return end_mark;
      endcase
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 7) == 0) begin
            gap        = 0;
            burst_left = $urandom_range(100, 300);
         end else begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 40);
         end
         repeat (gap) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
         end
      end
      burst_left--;
   endtask

   task automatic send_item(logic [7:0] b, logic eoi);
      kind_type kind;
      pace_sender();
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.data_byte    <= b;
      req_ch.end_of_input <= eoi;
      do @(posedge clock); while (!req_ch.ready);
      if (scan_phase == LINE_SCAN || eoi) begin
         scan_items++;
      end
      if (scan_step(b, eoi, kind)) begin
         expected_kinds.push_back(fixed_row ? fixed_kind : kind);
      end
   endtask

   task automatic send_stream();
      foreach (stream_bytes[i]) begin
         send_item(stream_bytes[i], 1'b0);
      end
      send_item(8'($urandom_range(0, 255)), 1'b1);
      stream_bytes.delete();
   endtask

   task automatic append_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         stream_bytes.push_back(8'(s[i]));
      end
   endtask

   task automatic append_random(int n, bit no_lf);
      logic [7:0] b;
      repeat (n) begin
         b = 8'($urandom_range(0, 255));
         if (no_lf && b == CHAR_LF) begin
            b = 8'h2E;
         end
         stream_bytes.push_back(b);
      end
   endtask

   task automatic build_random_stream();
      int    lines;
      int    pick;
      int    base;
      string text;
      lines = $urandom_range(0, 3);
      repeat (lines) begin
         pick = $urandom_range(0, 19);
         if (pick < 10) begin
            append_random($urandom_range(0, 30), 1'b1);
         end else if (pick < 14) begin
            text = marker_text($urandom_range(0, 4));
            append_text(text.substr(0, $urandom_range(0, text.len() - 1)));
            append_random(1, 1'b1);
         end else if (pick == 17) begin
            append_random($urandom_range(LINE_CHARS - 30, 2 * LINE_CHARS + 80), 1'b1);
         end else if (pick > 17) begin
            append_text(end_mark);
            append_random($urandom_range(0, 10), 1'b1);
         end
         stream_bytes.push_back(CHAR_LF);
      end

      pick = $urandom_range(0, 15);
      if (pick < 4) begin
         append_text(msg_line);
      end else if (pick < 7) begin
         append_text(smsg_line);
      end else if (pick < 10) begin
         append_text(sig_line);
      end else if (pick == 10) begin
         append_text(begin_mark);
         append_random($urandom_range(0, 25), 1'b1);
      end else if (pick == 11) begin
         text = marker_text($urandom_range(0, 2));
         base = stream_bytes.size();
         append_text(text);
         stream_bytes[base + $urandom_range(0, text.len() - 1)] = 8'($urandom_range(0, 255));
      end else if (pick == 12) begin
         text = marker_text($urandom_range(0, 2));
         append_text(text.substr(0, $urandom_range(0, text.len() - 2)));
      end else if (pick == 13) begin
         append_text(end_mark);
         append_random($urandom_range(0, 10), 1'b1);
      end else if (pick == 15) begin
         append_random($urandom_range(0, 40), 1'b0);
      end

      repeat ($urandom_range(0, 4)) begin
         case ($urandom_range(0, 2))
            0:       stream_bytes.push_back(8'h20);
            1:       stream_bytes.push_back(8'h09);
            default: stream_bytes.push_back(8'h0D);
         endcase
      end
      if ($urandom_range(0, 5) == 0) begin
         append_random(1, 1'b1);
      end
      if ($urandom_range(0, 3) != 0) begin
         stream_bytes.push_back(CHAR_LF);
      end
      append_random($urandom_range(0, 6), 1'b0);
   endtask

   // response-side stall pattern
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 120);
      end
      stall_left--;
      case (stall_mode)
         0:       rsp_ch.ready <= 1'b1;
         1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
         2:       rsp_ch.ready <= ($urandom_range(0, 4) == 0);
         default: rsp_ch.ready <= ((stall_left % 16) >= 12);
      endcase
   end

   always @(posedge clock) begin : check_rsp
      kind_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_kinds.size() == 0) begin
            report_mismatch($sformatf("unexpected armor_kind %0d", rsp_ch.armor_kind));
         end else begin
            want = expected_kinds.pop_front();
            if (rsp_ch.armor_kind !== want) begin
               report_mismatch($sformatf("armor_kind %0d, expected %0d",
                                         rsp_ch.armor_kind, want));
            end
         end
      end
   end

   initial begin : stimulus
      int waited;
      req_ch.valid        = 1'b0;
      req_ch.data_byte    = 8'h00;
      req_ch.end_of_input = 1'b0;
      rsp_ch.ready        = 1'b0;
      restart_scan();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_cases[i]) begin
         fixed_row  = directed_cases[i].fixed;
         fixed_kind = directed_cases[i].kind;
         append_text(directed_cases[i].head);
         repeat (directed_cases[i].fill_n) begin
            stream_bytes.push_back(directed_cases[i].fill_b);
         end
         append_text(directed_cases[i].tail);
         send_stream();
      end
      fixed_row = 1'b0;

      scan_items = 0;
      while (scan_items < MIN_SCAN_ITEMS) begin
         build_random_stream();
         send_stream();
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      waited = 0;
      while (expected_kinds.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_kinds.size() != 0) begin
         report_mismatch($sformatf("%0d armor_kind results never arrived",
                                   expected_kinds.size()));
      end
      if (mismatches == 0) begin
         $display("armor_header_classifier_top verification clean");
      end else begin
         $display("armor_header_classifier_top verification failed");
      end
      $finish;
   end

endmodule
